// ===== hdl/wlt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wlt_pkg
// Shared types, register indexes and helpers of the window tiling layout.
// ----------------------------------------------------------------------------
package wlt_pkg;

    localparam int MAX_WINDOWS = 64;
    localparam int COL_MAX     = 8;   // ceil(sqrt(MAX_WINDOWS))
    localparam int GEO_W       = 18;
    localparam int OUT_W       = 15;
    localparam int ACC_W       = 25;

    localparam logic [1:0] MODE_MASTER  = 2'd0;
    localparam logic [1:0] MODE_MONOCLE = 2'd1;
    localparam logic [1:0] MODE_GRID    = 2'd2;

    typedef enum logic [2:0] {
        REG_LAYOUT_MODE   = 3'd0,
        REG_WINDOW_COUNT  = 3'd1,
        REG_MASTER_COUNT  = 3'd2,
        REG_MASTER_RATIO  = 3'd3,
        REG_SCREEN_WIDTH  = 3'd4,
        REG_SCREEN_HEIGHT = 3'd5,
        REG_GAP_SIZE      = 3'd6
    } reg_index_t;

    // one geometry lane: x = xb + x_mul * xs, y = yb + y_mul * ys
    typedef struct packed {
        logic signed [GEO_W-1:0] xb;
        logic signed [GEO_W-1:0] xs;
        logic signed [GEO_W-1:0] yb;
        logic signed [GEO_W-1:0] ys;
        logic signed [OUT_W-1:0] w;
        logic signed [OUT_W-1:0] h;
    } geo_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [6:0] n;
        logic [6:0] m;
        logic [3:0] cols;
        logic       split;
    } status_t;

    typedef struct packed {
        logic       oor;
        logic       lane_b;
        logic [2:0] x_mul;
        logic [5:0] y_mul;
    } entry_t;

    function automatic logic signed [OUT_W-1:0] sat15(input logic signed [ACC_W-1:0] v);
        logic signed [OUT_W-1:0] r;
        if (v < -ACC_W'(16384))
            r = -OUT_W'(16384);
        else if (v > ACC_W'(16383))
            r = OUT_W'(16383);
        else
            r = v[OUT_W-1:0];
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/wlt_setup.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wlt_setup
// Configuration registers and the sequencer that derives per-layout geometry
// (counts, master width, grid shape, piece sizes by a serial divider).
// ----------------------------------------------------------------------------
module wlt_setup (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_addr,
    input  wire logic [16:0]        cfg_wdata,
    output logic                    busy,
    output wlt_pkg::status_t        status,
    output wlt_pkg::geo_t           lane_a,
    output wlt_pkg::geo_t           lane_b
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_PREP  = 6'b000010,
        ST_ROWS  = 6'b000100,
        ST_LOAD  = 6'b001000,
        ST_DIV   = 6'b010000,
        ST_LANES = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [1:0]  mode_reg;
    logic [6:0]  wcount_reg;
    logic [6:0]  mcount_reg;
    logic [16:0] ratio_reg;
    logic [12:0] sw_reg;
    logic [12:0] sh_reg;
    logic [7:0]  gap_reg;

    logic [6:0]  n_reg, m_reg;
    logic [13:0] mw_reg;
    logic [3:0]  cols_reg, rows_reg;
    logic [2:0]  job_reg;
    logic [3:0]  step_reg;
    logic [14:0] dvd_reg;
    logic [6:0]  rem_reg;
    logic [6:0]  dvs_reg;
    logic        neg_reg;
    logic signed [15:0] d_reg [5];

    wlt_pkg::status_t status_reg;
    wlt_pkg::geo_t    lane_a_reg, lane_b_reg;

    // PREP arithmetic
    logic [6:0]  n_clamp, m_clamp;
    logic [16:0] ratio_sat;
    logic [29:0] mw_prod;
    logic [3:0]  cols_calc, rows_calc;

    always_comb begin
        n_clamp = (wcount_reg > 7'(wlt_pkg::MAX_WINDOWS)) ? 7'(wlt_pkg::MAX_WINDOWS)
                                                           : wcount_reg;
        m_clamp = (mcount_reg == 7'd0) ? 7'd1 : mcount_reg;
        if (m_clamp > n_clamp)
            m_clamp = n_clamp;
        ratio_sat = (ratio_reg > 17'd65536) ? 17'd65536 : ratio_reg;
        mw_prod   = {17'd0, sw_reg} * {13'd0, ratio_sat};
        cols_calc = 4'd1;
        for (int c = 1; c < wlt_pkg::COL_MAX; c++) begin
            if (7'(c * c) < n_clamp)
                cols_calc = cols_calc + 4'd1;
        end
        rows_calc = 4'd0;
        for (int k = 0; k < wlt_pkg::COL_MAX; k++) begin
            if (7'(k) * {3'd0, cols_reg} < n_reg)
                rows_calc = rows_calc + 4'd1;
        end
        if (rows_calc == 4'd0)
            rows_calc = 4'd1;
    end

    // divider job operands: piece(span, cnt, g) = (span - (cnt + 1) * g) / cnt
    logic [12:0] span;
    logic [6:0]  cnt;
    logic [7:0]  cnt1;
    logic [15:0] gprod;
    logic signed [16:0] num, mag;

    always_comb begin
        case (job_reg)
            3'd0: begin span = sh_reg; cnt = n_reg; end
            3'd1: begin span = sh_reg; cnt = m_reg; end
            3'd2: begin span = sh_reg; cnt = n_reg - m_reg; end
            3'd3: begin span = sw_reg; cnt = {3'd0, cols_reg}; end
            default: begin span = sh_reg; cnt = {3'd0, rows_reg}; end
        endcase
        if (cnt == 7'd0)
            cnt = 7'd1;
        cnt1  = {1'b0, cnt} + 8'd1;
        gprod = {8'd0, cnt1} * {8'd0, gap_reg};
        num   = $signed({4'd0, span}) - $signed({1'b0, gprod});
        mag   = num[16] ? -num : num;
    end

    // one restoring step per cycle
    logic [7:0]  shifted, rem_sub;
    logic        ge;
    logic [14:0] dvd_next;
    logic signed [15:0] q_signed;

    always_comb begin
        shifted  = {rem_reg, dvd_reg[14]};
        ge       = shifted >= {1'b0, dvs_reg};
        rem_sub  = ge ? shifted - {1'b0, dvs_reg} : shifted;
        dvd_next = {dvd_reg[13:0], ge};
        q_signed = neg_reg ? -$signed({1'b0, dvd_next}) : $signed({1'b0, dvd_next});
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  state_next = ST_IDLE;
            ST_PREP:  state_next = ST_ROWS;
            ST_ROWS:  state_next = ST_LOAD;
            ST_LOAD:  state_next = ST_DIV;
            ST_DIV: begin
                if (step_reg == 4'd14)
                    state_next = (job_reg == 3'd4) ? ST_LANES : ST_LOAD;
            end
            ST_LANES: state_next = ST_IDLE;
            default:  state_next = ST_PREP;
        endcase
        if (cfg_we)
            state_next = ST_PREP;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_PREP;
            mode_reg   <= wlt_pkg::MODE_MASTER;
            wcount_reg <= 7'd0;
            mcount_reg <= 7'd1;
            ratio_reg  <= 17'd32768;
            sw_reg     <= 13'd1920;
            sh_reg     <= 13'd1080;
            gap_reg    <= 8'd0;
            job_reg    <= 3'd0;
            step_reg   <= 4'd0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                case (cfg_addr)
                    wlt_pkg::REG_LAYOUT_MODE:   mode_reg   <= cfg_wdata[1:0];
                    wlt_pkg::REG_WINDOW_COUNT:  wcount_reg <= cfg_wdata[6:0];
                    wlt_pkg::REG_MASTER_COUNT:  mcount_reg <= cfg_wdata[6:0];
                    wlt_pkg::REG_MASTER_RATIO:  ratio_reg  <= cfg_wdata;
                    wlt_pkg::REG_SCREEN_WIDTH:  sw_reg     <= cfg_wdata[12:0];
                    wlt_pkg::REG_SCREEN_HEIGHT: sh_reg     <= cfg_wdata[12:0];
                    wlt_pkg::REG_GAP_SIZE:      gap_reg    <= cfg_wdata[7:0];
                    default: ;
                endcase
            end
            case (state_reg)
                ST_ROWS: job_reg <= 3'd0;
                ST_LOAD: step_reg <= 4'd0;
                ST_DIV: begin
                    step_reg <= step_reg + 4'd1;
                    if (step_reg == 4'd14)
                        job_reg <= job_reg + 3'd1;
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_PREP: begin
                n_reg    <= n_clamp;
                m_reg    <= m_clamp;
                mw_reg   <= mw_prod[29:16];
                cols_reg <= cols_calc;
            end
            ST_ROWS: rows_reg <= rows_calc;
            ST_LOAD: begin
                dvd_reg <= mag[14:0];
                neg_reg <= num[16];
                dvs_reg <= cnt;
                rem_reg <= 7'd0;
            end
            ST_DIV: begin
                dvd_reg <= dvd_next;
                rem_reg <= rem_sub[6:0];
                if (step_reg == 4'd14)
                    d_reg[job_reg] <= q_signed;
            end
            default: ;
        endcase
    end

    // lane geometry
    logic signed [17:0] g18, sw18, sh18, mw18;
    logic signed [17:0] d0, d1, d2, d3, d4;
    wlt_pkg::geo_t    la, lb;
    wlt_pkg::status_t st;

    always_comb begin
        g18  = $signed({10'd0, gap_reg});
        sw18 = $signed({5'd0, sw_reg});
        sh18 = $signed({5'd0, sh_reg});
        mw18 = $signed({4'd0, mw_reg});
        d0   = 18'(d_reg[0]);
        d1   = 18'(d_reg[1]);
        d2   = 18'(d_reg[2]);
        d3   = 18'(d_reg[3]);
        d4   = 18'(d_reg[4]);
        la   = '0;
        lb   = '0;
        st.mode  = mode_reg;
        st.n     = n_reg;
        st.m     = m_reg;
        st.cols  = cols_reg;
        st.split = 1'b0;
        if (mode_reg == wlt_pkg::MODE_MONOCLE) begin
            la.w = wlt_pkg::sat15(25'(sw18));
            la.h = wlt_pkg::sat15(25'(sh18));
        end else if (mode_reg == wlt_pkg::MODE_MASTER) begin
            la.xb = g18;
            la.yb = g18;
            if (n_reg == 7'd1) begin
                la.w = wlt_pkg::sat15(25'(sw18 - g18 - g18));
                la.h = wlt_pkg::sat15(25'(sh18 - g18 - g18));
            end else if (m_reg == n_reg) begin
                la.ys = d0 + g18;
                la.w  = wlt_pkg::sat15(25'(sw18 - g18 - g18));
                la.h  = wlt_pkg::sat15(25'(d0));
            end else begin
                st.split = 1'b1;
                la.ys = d1 + g18;
                la.w  = wlt_pkg::sat15(25'(mw18 - g18));
                la.h  = wlt_pkg::sat15(25'(d1));
                lb.xb = mw18 + g18 + g18;
                lb.yb = g18;
                lb.ys = d2 + g18;
                lb.w  = wlt_pkg::sat15(25'(sw18 - mw18 - g18 - g18 - g18));
                lb.h  = wlt_pkg::sat15(25'(d2));
            end
        end else begin
            la.xb = g18;
            la.xs = d3 + g18;
            la.yb = g18;
            la.ys = d4 + g18;
            la.w  = wlt_pkg::sat15(25'(d3));
            la.h  = wlt_pkg::sat15(25'(d4));
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_LANES) begin
            lane_a_reg <= la;
            lane_b_reg <= lb;
            status_reg <= st;
        end
    end

    assign busy   = (state_reg != ST_IDLE);
    assign status = status_reg;
    assign lane_a = lane_a_reg;
    assign lane_b = lane_b_reg;

endmodule
`default_nettype wire

// ===== hdl/wlt_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wlt_front
// Classifies an incoming window index: range check, lane choice and the
// row and column multipliers for the back end.
// ----------------------------------------------------------------------------
module wlt_front (
    input  wire logic [5:0]       window_index,
    input  wire wlt_pkg::status_t status,
    output wlt_pkg::entry_t       entry
);

    logic [2:0] row;
    logic [6:0] row_base;
    logic [6:0] col_full;
    logic       in_stack;

    always_comb begin
        // row = index / cols by comparing against multiples of cols
        row = 3'd0;
        for (int k = 1; k < wlt_pkg::COL_MAX; k++) begin
            if ({1'b0, window_index} >= 7'(k) * {3'd0, status.cols})
                row = row + 3'd1;
        end
        row_base = {4'd0, row} * {3'd0, status.cols};
        col_full = {1'b0, window_index} - row_base;
        in_stack = status.split && ({1'b0, window_index} >= status.m);

        entry.oor    = {1'b0, window_index} >= status.n;
        entry.lane_b = 1'b0;
        entry.x_mul  = 3'd0;
        entry.y_mul  = 6'd0;
        if (status.mode == wlt_pkg::MODE_MASTER) begin
            entry.lane_b = in_stack;
            entry.y_mul  = in_stack ? 6'({1'b0, window_index} - status.m) : window_index;
        end else if (status.mode != wlt_pkg::MODE_MONOCLE) begin
            entry.x_mul = col_full[2:0];
            entry.y_mul = {3'd0, row};
        end
    end

endmodule
`default_nettype wire

// ===== hdl/wlt_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wlt_fifo
// Short queue of classified items between the front and back ends.
// ----------------------------------------------------------------------------
module wlt_fifo (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            wr_en,
    input  wire wlt_pkg::entry_t wr_data,
    output logic                 full,
    input  wire logic            rd_en,
    output wlt_pkg::entry_t      rd_data,
    output logic                 empty
);

    wlt_pkg::entry_t mem_reg [4];
    logic [1:0] wptr_reg, rptr_reg;
    logic [2:0] count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= 2'd0;
            rptr_reg  <= 2'd0;
            count_reg <= 3'd0;
        end else begin
            if (wr_en)
                wptr_reg <= wptr_reg + 2'd1;
            if (rd_en)
                rptr_reg <= rptr_reg + 2'd1;
            if (wr_en && !rd_en)
                count_reg <= count_reg + 3'd1;
            else if (rd_en && !wr_en)
                count_reg <= count_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en)
            mem_reg[wptr_reg] <= wr_data;
    end

    assign rd_data = mem_reg[rptr_reg];
    assign full    = (count_reg == 3'd4);
    assign empty   = (count_reg == 3'd0);

endmodule
`default_nettype wire

// ===== hdl/wlt_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wlt_back
// Computes the rectangle of a queued item and holds it in the output register.
// ----------------------------------------------------------------------------
module wlt_back (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire wlt_pkg::entry_t    entry,
    input  wire logic               empty,
    output logic                    pop,
    input  wire wlt_pkg::geo_t      lane_a,
    input  wire wlt_pkg::geo_t      lane_b,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [14:0]      m_x_pos,
    output logic signed [14:0]      m_y_pos,
    output logic signed [14:0]      m_win_width,
    output logic signed [14:0]      m_win_height,
    output logic                    m_out_of_range
);

    wlt_pkg::geo_t lane;
    logic signed [21:0] xprod;
    logic signed [24:0] yprod;
    logic signed [24:0] xsum, ysum;

    logic              valid_reg;
    logic signed [14:0] x_reg, y_reg, w_reg, h_reg;
    logic              oor_reg;

    always_comb begin
        lane  = entry.lane_b ? lane_b : lane_a;
        xprod = $signed({1'b0, entry.x_mul}) * lane.xs;
        yprod = $signed({1'b0, entry.y_mul}) * lane.ys;
        xsum  = 25'(lane.xb) + 25'(xprod);
        ysum  = 25'(lane.yb) + yprod;
    end

    assign pop = !empty && (!valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn)
            valid_reg <= 1'b0;
        else if (pop)
            valid_reg <= 1'b1;
        else if (m_ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            oor_reg <= entry.oor;
            if (entry.oor) begin
                x_reg <= '0;
                y_reg <= '0;
                w_reg <= '0;
                h_reg <= '0;
            end else begin
                x_reg <= wlt_pkg::sat15(xsum);
                y_reg <= wlt_pkg::sat15(ysum);
                w_reg <= lane.w;
                h_reg <= lane.h;
            end
        end
    end

    assign m_valid        = valid_reg;
    assign m_x_pos        = x_reg;
    assign m_y_pos        = y_reg;
    assign m_win_width    = w_reg;
    assign m_win_height   = h_reg;
    assign m_out_of_range = oor_reg;

endmodule
`default_nettype wire

// ===== hdl/window_tile_layout.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// window_tile_layout
// Per-window rectangle for master-stack, monocle and grid tiling with gaps.
// ----------------------------------------------------------------------------
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+------------------
//  input    | s_window_index                          | s_valid / s_ready
//  result   | m_x_pos m_y_pos m_win_width m_win_height| m_valid / m_ready
//           | m_out_of_range                          |
//  config   | cfg_addr cfg_wdata                      | cfg_we
//
// One item per cycle sustained while the sequencer is idle and results are
// taken; an accepted item is registered in the queue (front classify), then
// popped and computed into the output register (back). After reset and every
// write the geometry sequencer runs (five piece sizes, one-bit-per-cycle
// divider), with s_ready low. A stalled result backs up the four-entry queue, then s_ready.
// ----------------------------------------------------------------------------
module window_tile_layout (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_addr,
    input  wire logic [16:0]        cfg_wdata,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [5:0]         s_window_index,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [14:0]      m_x_pos,
    output logic signed [14:0]      m_y_pos,
    output logic signed [14:0]      m_win_width,
    output logic signed [14:0]      m_win_height,
    output logic                    m_out_of_range
);

    logic             busy;
    wlt_pkg::status_t status;
    wlt_pkg::geo_t    lane_a, lane_b;
    wlt_pkg::entry_t  wr_entry, rd_entry;
    logic             full, empty, pop;

    wlt_setup u_setup (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .busy      (busy),
        .status    (status),
        .lane_a    (lane_a),
        .lane_b    (lane_b)
    );

    wlt_front u_front (
        .window_index (s_window_index),
        .status       (status),
        .entry        (wr_entry)
    );

    assign s_ready = !busy && !full;

    wlt_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (s_valid && s_ready),
        .wr_data (wr_entry),
        .full    (full),
        .rd_en   (pop),
        .rd_data (rd_entry),
        .empty   (empty)
    );

    wlt_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .entry          (rd_entry),
        .empty          (empty),
        .pop            (pop),
        .lane_a         (lane_a),
        .lane_b         (lane_b),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_x_pos        (m_x_pos),
        .m_y_pos        (m_y_pos),
        .m_win_width    (m_win_width),
        .m_win_height   (m_win_height),
        .m_out_of_range (m_out_of_range)
    );

endmodule
`default_nettype wire

// ===== sim/tb_window_tile_layout.sv =====
// ----------------------------------------------------------------------------
// tb_window_tile_layout
// Self-checking bench for the window tiling layout block. A directed table
// covers the layout modes, clamping and range corners; random phases then
// reprogram the layout and stream indexes with random stalls on both sides.
// Each result is compared with a table rectangle or the in-bench predictor.
// ----------------------------------------------------------------------------
module tb_window_tile_layout;

    localparam logic [1:0] MODE_SPARE = 2'd3;   // undefined mode, acts as grid
    localparam int RAND_PHASES = 12;
    localparam int PHASE_ITEMS = 150;

    typedef struct {
        logic signed [14:0] x;
        logic signed [14:0] y;
        logic signed [14:0] w;
        logic signed [14:0] h;
        logic               oor;
    } rect_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [6:0]  n;
        logic [6:0]  m;
        logic [16:0] ratio;
        logic [12:0] sw;
        logic [12:0] sh;
        logic [7:0]  gap;
    } layout_t;

    typedef struct {
        layout_t    lay;
        logic [5:0] idx;
        bit         known;
        rect_t      rect;
    } dir_row_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_we = 1'b0;
    logic [2:0]         cfg_addr = '0;
    logic [16:0]        cfg_wdata = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [5:0]         s_window_index = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [14:0] m_x_pos, m_y_pos, m_win_width, m_win_height;
    logic               m_out_of_range;

    layout_t cur;
    rect_t   pending_rects[$];
    int      errors = 0;
    int      results_seen = 0;
    int      layouts_done = 0;
    bit      calm = 1'b0;        // no idling on either side when set
    dir_row_t dir_rows[20];

    window_tile_layout i_dut (
        .aclk, .aresetn, .cfg_we, .cfg_addr, .cfg_wdata,
        .s_valid, .s_ready, .s_window_index,
        .m_valid, .m_ready, .m_x_pos, .m_y_pos, .m_win_width, .m_win_height,
        .m_out_of_range
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic logic signed [14:0] clamp15(longint v);
        if (v < -16384) v = -16384;
        if (v > 16383) v = 16383;
        return v[14:0];
    endfunction

    function automatic longint split_span(longint span, longint cnt, longint g);
        return (span - (cnt + 1) * g) / cnt;
    endfunction

    function automatic rect_t tile_rect(layout_t l, logic [5:0] idx_in);
        rect_t  r;
        longint idx, n, m, sw, sh, g, x, y, w, h, ratio, mw, cols, rows, ww, wh;
        idx = idx_in; n = l.n; sw = l.sw; sh = l.sh; g = l.gap;
        x = 0; y = 0; w = 0; h = 0;
        if (n > wlt_pkg::MAX_WINDOWS) n = wlt_pkg::MAX_WINDOWS;
        if (idx >= n) begin
            r = '{x: 0, y: 0, w: 0, h: 0, oor: 1'b1};
            return r;
        end
        if (l.mode == wlt_pkg::MODE_MONOCLE) begin
            w = sw; h = sh;
        end else if (l.mode == wlt_pkg::MODE_MASTER) begin
            m = l.m;
            if (m < 1) m = 1;
            if (m > n) m = n;
            if (n == 1) begin
                x = g; y = g; w = sw - 2 * g; h = sh - 2 * g;
            end else if (m == n) begin
                wh = split_span(sh, n, g);
                x = g; y = g + idx * (wh + g); w = sw - 2 * g; h = wh;
            end else begin
                ratio = (l.ratio > 65536) ? 65536 : l.ratio;
                mw = (sw * ratio) >>> 16;
                if (idx < m) begin
                    wh = split_span(sh, m, g);
                    x = g; y = g + idx * (wh + g); w = mw - g; h = wh;
                end else begin
                    wh = split_span(sh, n - m, g);
                    x = mw + 2 * g; y = g + (idx - m) * (wh + g);
                    w = sw - mw - 3 * g; h = wh;
                end
            end
        end else begin
            cols = 1;
            while (cols * cols < n) cols++;
            rows = (n + cols - 1) / cols;
            if (rows < 1) rows = 1;
            ww = split_span(sw, cols, g);
            wh = split_span(sh, rows, g);
            x = g + (idx % cols) * (ww + g);
            y = g + (idx / cols) * (wh + g);
            w = ww; h = wh;
        end
        r = '{x: clamp15(x), y: clamp15(y), w: clamp15(w), h: clamp15(h), oor: 1'b0};
        return r;
    endfunction

    task automatic check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
        end
    endtask

    // result side: random backpressure, compare against oldest expectation
    always @(posedge aclk) begin
        rect_t e;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_rects.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, got x=%0d y=%0d",
                         $time, m_x_pos, m_y_pos);
            end else begin
                e = pending_rects.pop_front();
                check_field("x_pos", e.x, m_x_pos);
                check_field("y_pos", e.y, m_y_pos);
                check_field("win_width", e.w, m_win_width);
                check_field("win_height", e.h, m_win_height);
                check_field("out_of_range", e.oor, m_out_of_range);
            end
        end
        m_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 9);
    end

    // called right after a rising edge; leaves s_valid high once accepted
    task automatic send_index(logic [5:0] idx, bit known, rect_t exp_r);
        while (!calm && $urandom_range(0, 99) < 9) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_window_index <= idx;
        do @(posedge aclk); while (!s_ready);
        pending_rects.push_back(known ? exp_r : tile_rect(cur, idx));
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_rects.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic program_layout(layout_t l);
        drain();
        cfg_we <= 1'b1;
        cfg_addr <= wlt_pkg::REG_LAYOUT_MODE;   cfg_wdata <= 17'(l.mode);  @(posedge aclk);
        cfg_addr <= wlt_pkg::REG_WINDOW_COUNT;  cfg_wdata <= 17'(l.n);     @(posedge aclk);
        cfg_addr <= wlt_pkg::REG_MASTER_COUNT;  cfg_wdata <= 17'(l.m);     @(posedge aclk);
        cfg_addr <= wlt_pkg::REG_MASTER_RATIO;  cfg_wdata <= l.ratio;      @(posedge aclk);
        cfg_addr <= wlt_pkg::REG_SCREEN_WIDTH;  cfg_wdata <= 17'(l.sw);    @(posedge aclk);
        cfg_addr <= wlt_pkg::REG_SCREEN_HEIGHT; cfg_wdata <= 17'(l.sh);    @(posedge aclk);
        cfg_addr <= wlt_pkg::REG_GAP_SIZE;      cfg_wdata <= 17'(l.gap);   @(posedge aclk);
        cfg_we <= 1'b0;
        cur = l;
        layouts_done++;
    endtask

    function automatic logic [12:0] rand_screen();
        case ($urandom_range(0, 9))
            0: return 13'd0;
            1: return 13'd1;
            2: return 13'd8191;
            default: return 13'($urandom_range(200, 4000));
        endcase
    endfunction

    initial begin
        automatic rect_t   no_rect = '{x: 0, y: 0, w: 0, h: 0, oor: 1'b0};
        automatic rect_t   oor_rect = '{x: 0, y: 0, w: 0, h: 0, oor: 1'b1};
        automatic layout_t l;
        automatic logic [5:0] idx;
        dir_rows = '{
            '{'{wlt_pkg::MODE_MASTER, 0, 1, 32768, 1920, 1080, 0}, 0, 1, oor_rect},
            '{'{wlt_pkg::MODE_MONOCLE, 1, 1, 32768, 1920, 1080, 0}, 0, 1,
              '{x: 0, y: 0, w: 1920, h: 1080, oor: 1'b0}},
            '{'{wlt_pkg::MODE_MASTER, 1, 1, 32768, 1920, 1080, 10}, 0, 1,
              '{x: 10, y: 10, w: 1900, h: 1060, oor: 1'b0}},
            '{'{wlt_pkg::MODE_MASTER, 4, 1, 32768, 1920, 1080, 0}, 5, 1, oor_rect},
            '{'{wlt_pkg::MODE_MASTER, 4, 0, 32768, 1920, 1080, 8}, 0, 0, no_rect},
            '{'{wlt_pkg::MODE_MASTER, 4, 0, 32768, 1920, 1080, 8}, 3, 0, no_rect},
            '{'{wlt_pkg::MODE_MASTER, 4, 4, 32768, 1920, 1080, 8}, 2, 0, no_rect},
            '{'{wlt_pkg::MODE_MASTER, 5, 9, 32768, 1920, 1080, 8}, 4, 0, no_rect},
            '{'{wlt_pkg::MODE_MASTER, 3, 1, 131071, 1920, 1080, 4}, 2, 0, no_rect},
            '{'{wlt_pkg::MODE_MASTER, 3, 1, 0, 1920, 1080, 4}, 0, 0, no_rect},
            '{'{wlt_pkg::MODE_MASTER, 3, 1, 65536, 1920, 1080, 4}, 1, 0, no_rect},
            '{'{wlt_pkg::MODE_GRID, 64, 1, 32768, 8191, 8191, 255}, 63, 0, no_rect},
            '{'{wlt_pkg::MODE_GRID, 5, 1, 32768, 1920, 1080, 0}, 4, 0, no_rect},
            '{'{MODE_SPARE, 7, 1, 32768, 1920, 1080, 3}, 6, 0, no_rect},
            '{'{wlt_pkg::MODE_GRID, 127, 1, 32768, 1920, 1080, 3}, 63, 0, no_rect},
            '{'{wlt_pkg::MODE_MONOCLE, 2, 1, 32768, 0, 0, 0}, 1, 1, no_rect},
            '{'{wlt_pkg::MODE_MASTER, 64, 64, 32768, 1920, 1, 255}, 63, 0, no_rect},
            '{'{wlt_pkg::MODE_MASTER, 2, 1, 32768, 1, 1080, 255}, 1, 0, no_rect},
            '{'{wlt_pkg::MODE_MONOCLE, 64, 1, 32768, 8191, 8191, 0}, 63, 1,
              '{x: 0, y: 0, w: 8191, h: 8191, oor: 1'b0}},
            '{'{wlt_pkg::MODE_MASTER, 10, 3, 32768, 1920, 1080, 255}, 9, 0, no_rect}
        };
        cur = '{wlt_pkg::MODE_MASTER, 0, 1, 32768, 1920, 1080, 0};
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table; first row runs on the reset values
        foreach (dir_rows[i]) begin
            if (i != 0 && dir_rows[i].lay != cur) program_layout(dir_rows[i].lay);
            send_index(dir_rows[i].idx, dir_rows[i].known, dir_rows[i].rect);
        end

        for (int p = 0; p < RAND_PHASES; p++) begin
            l.mode  = 2'($urandom_range(0, 3));
            case ($urandom_range(0, 7))
                0: l.n = 7'($urandom_range(65, 127));
                1: l.n = 7'd64;
                2: l.n = 7'd0;
                default: l.n = 7'($urandom_range(1, 20));
            endcase
            l.m     = ($urandom_range(0, 3) == 0) ? 7'($urandom) : 7'($urandom_range(0, 4));
            l.ratio = 17'($urandom);
            l.sw    = rand_screen();
            l.sh    = rand_screen();
            l.gap   = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 12));
            if (p == RAND_PHASES - 1)
                l = '{wlt_pkg::MODE_MASTER, 127, 127, 131071, 8191, 8191, 255};
            program_layout(l);
            calm = (p == 3);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (l.n != 0 && $urandom_range(0, 99) < 85)
                    idx = 6'($urandom_range(0, (l.n > 64 ? 64 : l.n) - 1));
                else
                    idx = 6'($urandom);
                send_index(idx, 1'b0, no_rect);
            end
        end
        calm = 1'b0;
        drain();

        $display("Covered %0d layout settings and %0d results across all modes,",
                 layouts_done, results_seen);
        $display("including clamped counts and ratios, gap extremes and stalls.");
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #20000000;
        $display("Timeout waiting for results");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/wlt_pkg.sv
hdl/wlt_setup.sv
hdl/wlt_front.sv
hdl/wlt_fifo.sv
hdl/wlt_back.sv
hdl/window_tile_layout.sv
sim/tb_window_tile_layout.sv
